/* rtl/ypvm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypvm_pkg
// Shared widths, limits, control struct and the sine/cosine table builder
// for the yaw/pitch view matrix block.
// ----------------------------------------------------------------------------
package ypvm_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int STEP_W        = 11;
    localparam int POS_W         = 24;
    localparam int MTX_W         = 16;
    localparam int TRANS_W       = 25;
    localparam int YAW_W         = 12;
    localparam int PITCH_W       = 10;
    localparam int YAW_LIMIT     = 1256;
    localparam int PITCH_LIMIT   = 314;
    // table entry holds up to 2^20 signed
    localparam int SC_W          = 22;
    localparam int ADDR_W        = 11;
    localparam logic [63:0] Q_HALF_PI = 64'h1921FB54442D1846;

    typedef logic [2*SC_W-1:0] sc_rom_t [0:YAW_LIMIT];

    typedef struct packed {
        logic start;
        logic clr;
        logic sub;
    } mac_ctl_t;

    // (a * b) >> 60 on Q60 magnitudes
    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // rounded sine and cosine of m * 0.005 rad, packed {sin, cos}
    function automatic logic [2*SC_W-1:0] sc_entry(int m, int frac);
        logic [63:0]        mm;
        logic [63:0]        x;
        logic [63:0]        r2;
        logic [63:0]        term;
        logic [63:0]        half;
        logic signed [63:0] s;
        logic signed [63:0] c;
        logic signed [63:0] rs;
        logic signed [63:0] rc;
        logic signed [63:0] vs;
        logic signed [63:0] vc;
        logic [1:0]         quad;
        int                 sh;
        mm   = 64'(m);
        x    = ((mm / 25) << 57) + (((mm % 25) << 57) / 25);
        quad = 2'd0;
        for (int q = 0; q < 4; q++) begin
            if (x >= Q_HALF_PI) begin
                x    = x - Q_HALF_PI;
                quad = quad + 2'd1;
            end
        end
        r2   = qmul(x, x);
        s    = x;
        term = x;
        for (int i = 1; i < 30; i++) begin
            if (term != 0) begin
                term = qmul(term, r2) / 64'((2 * i) * (2 * i + 1));
                s    = (i % 2 == 1) ? s - term : s + term;
            end
        end
        c    = 64'sh1000000000000000;
        term = 64'h1000000000000000;
        for (int i = 1; i < 30; i++) begin
            if (term != 0) begin
                term = qmul(term, r2) / 64'((2 * i - 1) * (2 * i));
                c    = (i % 2 == 1) ? c - term : c + term;
            end
        end
        unique case (quad)
            2'd0: begin rs = s;  rc = c;  end
            2'd1: begin rs = c;  rc = -s; end
            2'd2: begin rs = -s; rc = -c; end
            default: begin rs = -c; rc = s; end
        endcase
        sh   = 60 - frac;
        half = 64'd1 << (sh - 1);
        if (rs >= 0)
            vs = $signed((rs + half) >> sh);
        else
            vs = -$signed(((-rs) + half) >> sh);
        if (rc >= 0)
            vc = $signed((rc + half) >> sh);
        else
            vc = -$signed(((-rc) + half) >> sh);
        return {vs[SC_W-1:0], vc[SC_W-1:0]};
    endfunction

    function automatic sc_rom_t build_rom(int frac);
        sc_rom_t r;
        for (int k = 0; k <= YAW_LIMIT; k++)
            r[k] = sc_entry(k, frac);
        return r;
    endfunction

    function automatic logic signed [MTX_W-1:0] sat_mtx(logic signed [63:0] v);
        if (v > 64'sd32767)
            return 16'sh7FFF;
        else if (v < -64'sd32768)
            return 16'sh8000;
        else
            return v[MTX_W-1:0];
    endfunction

    function automatic logic signed [TRANS_W-1:0] sat_trans(logic signed [63:0] v);
        if (v > 64'sd16777215)
            return 25'sh0FFFFFF;
        else if (v < -64'sd16777216)
            return 25'sh1000000;
        else
            return v[TRANS_W-1:0];
    endfunction

endpackage

/* rtl/ypvm_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypvm_in_if
// Input channel: angle steps and camera position.
// ----------------------------------------------------------------------------
interface ypvm_in_if;
    logic               valid;
    logic               ready;
    logic signed [10:0] yaw_step;
    logic signed [10:0] pitch_step;
    logic signed [23:0] position_x;
    logic signed [23:0] position_y;
    logic signed [23:0] position_z;

    modport source (output valid, yaw_step, pitch_step, position_x, position_y,
                    position_z, input ready);
    modport sink   (input valid, yaw_step, pitch_step, position_x, position_y,
                    position_z, output ready);
endinterface

/* rtl/ypvm_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypvm_out_if
// Output channel: view rotation rows and translation.
// ----------------------------------------------------------------------------
interface ypvm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [15:0] back_x;
    logic signed [15:0] back_y;
    logic signed [15:0] back_z;
    logic signed [24:0] trans_x;
    logic signed [24:0] trans_y;
    logic signed [24:0] trans_z;

    modport source (output valid, right_x, right_y, right_z, up_x, up_y, up_z,
                    back_x, back_y, back_z, trans_x, trans_y, trans_z,
                    input ready);
    modport sink   (input valid, right_x, right_y, right_z, up_x, up_y, up_z,
                    back_x, back_y, back_z, trans_x, trans_y, trans_z,
                    output ready);
endinterface

/* rtl/ypvm_smac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypvm_smac
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle,
// LSB first, the sign bit weighted negative.
// ----------------------------------------------------------------------------
module ypvm_smac #(
    parameter int AW = 24,
    parameter int BW = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ypvm_pkg::mac_ctl_t          ctl,
    input  logic signed [AW-1:0]        a,
    input  logic signed [BW-1:0]        b,
    output logic signed [AW+BW+1:0]     acc,
    output logic                        done
);
    import ypvm_pkg::*;

    localparam int ACC_W = AW + BW + 2;
    localparam int CNT_W = $clog2(BW);

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] a_sh_reg, a_sh_next;
    logic [BW-1:0]           b_sh_reg, b_sh_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic                    sub_reg, sub_next;
    logic                    last;

    assign last = (cnt_reg == CNT_W'(BW - 1));

    // one shift-add step per cycle
    always_comb
    begin
        acc_next  = acc_reg;
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        sub_next  = sub_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            a_sh_next = ACC_W'(a);
            b_sh_next = b;
            cnt_next  = '0;
            busy_next = 1'b1;
            sub_next  = ctl.sub;
            if (ctl.clr)
                acc_next = '0;
        end
        else if (busy_reg)
        begin
            if (b_sh_reg[0])
                acc_next = (sub_reg ^ last) ? acc_reg - a_sh_reg : acc_reg + a_sh_reg;
            a_sh_next = a_sh_reg <<< 1;
            b_sh_next = b_sh_reg >> 1;
            cnt_next  = cnt_reg + CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
        sub_reg  <= sub_next;
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

/* rtl/yaw_pitch_view_matrix_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaw_pitch_view_matrix_top
// Takes a new item only while idle, so one item is in flight at a time;
//   all 13 products run on the single bit-serial multiply-accumulate unit,
//   whose multiplier width is BW = max(16, FRAC_BITS + 2).
// Reset clears yaw and pitch to zero and empties the output register.
// ----------------------------------------------------------------------------
module yaw_pitch_view_matrix_top #(
    parameter int FRAC_BITS = ypvm_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ypvm_in_if.sink     cmd,
    ypvm_out_if.source  view
);
    import ypvm_pkg::*;

    localparam int BW    = (FRAC_BITS + 2 > MTX_W) ? FRAC_BITS + 2 : MTX_W;
    localparam int AW    = POS_W;
    localparam int ACC_W = AW + BW + 2;
    localparam sc_rom_t SC_ROM = build_rom(FRAC_BITS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_YAW   = 3'd1;
    localparam logic [2:0] S_PITCH = 3'd2;
    localparam logic [2:0] S_TRIG  = 3'd3;
    localparam logic [2:0] S_ISSUE = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;

    logic signed [YAW_W-1:0]   yaw_reg, yaw_next;
    logic signed [PITCH_W-1:0] pitch_reg, pitch_next;
    logic signed [POS_W-1:0]   pos_reg [0:2];
    logic signed [SC_W-1:0]    sy_reg, cy_reg, sp_reg, cp_reg;
    logic signed [MTX_W-1:0]   m_reg [0:8];
    logic signed [TRANS_W-1:0] t_reg [0:2];

    logic                      trans_ph_reg, trans_ph_next;
    logic [1:0]                k_reg, k_next;
    logic [1:0]                row_reg, row_next;
    logic [1:0]                col_reg, col_next;

    logic [ADDR_W-1:0]         rom_addr;
    logic [2*SC_W-1:0]         rom_q_reg;
    logic signed [SC_W-1:0]    rom_sin, rom_cos;

    logic                      out_valid_reg;
    logic signed [MTX_W-1:0]   out_m_reg [0:8];
    logic signed [TRANS_W-1:0] out_t_reg [0:2];

    mac_ctl_t                  mac_ctl;
    logic signed [AW-1:0]      mac_a;
    logic signed [BW-1:0]      mac_b;
    logic signed [ACC_W-1:0]   mac_acc;
    logic                      mac_done;
    logic signed [63:0]        acc_sh;
    logic [3:0]                m_idx;

    logic accept;
    logic signed [YAW_W:0]     yaw_sum;
    logic signed [YAW_W-1:0]   pitch_sum;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);

    // angle update: yaw wraps to zero past the limit, pitch clamps
    assign yaw_sum   = (YAW_W+1)'(yaw_reg) + (YAW_W+1)'(cmd.yaw_step);
    assign pitch_sum = YAW_W'(pitch_reg) + YAW_W'(cmd.pitch_step);

    always_comb
    begin
        yaw_next = yaw_reg;
        if ((cmd.yaw_step > 0 && yaw_sum > (YAW_W+1)'(YAW_LIMIT)) ||
            (cmd.yaw_step < 0 && yaw_sum < -(YAW_W+1)'(YAW_LIMIT)))
            yaw_next = '0;
        else
            yaw_next = yaw_sum[YAW_W-1:0];
        if (pitch_sum > YAW_W'(PITCH_LIMIT))
            pitch_next = PITCH_W'(PITCH_LIMIT);
        else if (pitch_sum < -YAW_W'(PITCH_LIMIT))
            pitch_next = -PITCH_W'(PITCH_LIMIT);
        else
            pitch_next = pitch_sum[PITCH_W-1:0];
    end

    // sine/cosine table lookup on angle magnitude
    always_comb
    begin
        if (state_reg == S_YAW)
            rom_addr = yaw_reg[YAW_W-1] ? ADDR_W'(-yaw_reg) : ADDR_W'(yaw_reg);
        else
            rom_addr = pitch_reg[PITCH_W-1] ? ADDR_W'(-pitch_reg) : ADDR_W'(pitch_reg);
    end

    always_ff @(posedge clk)
    begin
        rom_q_reg <= SC_ROM[rom_addr];
    end

    assign rom_sin = rom_q_reg[2*SC_W-1:SC_W];
    assign rom_cos = rom_q_reg[SC_W-1:0];

    // operand select for the current product
    assign m_idx = 4'(row_reg) * 4'd3 + 4'(col_reg);

    always_comb
    begin
        mac_a = pos_reg[col_reg];
        mac_b = BW'(m_reg[m_idx]);
        if (!trans_ph_reg)
        begin
            unique case (k_reg)
                2'd0: begin mac_a = AW'(cy_reg); mac_b = BW'(sp_reg); end
                2'd1: begin mac_a = AW'(sy_reg); mac_b = BW'(sp_reg); end
                2'd2: begin mac_a = AW'(cp_reg); mac_b = BW'(cy_reg); end
                default: begin mac_a = AW'(cp_reg); mac_b = BW'(sy_reg); end
            endcase
        end
        mac_ctl.start = (state_reg == S_ISSUE);
        mac_ctl.clr   = !trans_ph_reg || (col_reg == 2'd0);
        mac_ctl.sub   = 1'b1;
    end

    ypvm_smac #(
        .AW (AW),
        .BW (BW)
    ) u_smac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (mac_acc),
        .done  (mac_done)
    );

    assign acc_sh = 64'(mac_acc) >>> FRAC_BITS;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        trans_ph_next = trans_ph_reg;
        k_next        = k_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = S_YAW;
            S_YAW:
                state_next = S_PITCH;
            S_PITCH:
                state_next = S_TRIG;
            S_TRIG:
            begin
                trans_ph_next = 1'b0;
                k_next        = 2'd0;
                row_next      = 2'd0;
                col_next      = 2'd0;
                state_next    = S_ISSUE;
            end
            S_ISSUE:
                state_next = S_WAIT;
            S_WAIT:
                if (mac_done)
                begin
                    state_next = S_ISSUE;
                    if (!trans_ph_reg)
                    begin
                        k_next = k_reg + 2'd1;
                        if (k_reg == 2'd3)
                            trans_ph_next = 1'b1;
                    end
                    else if (col_reg != 2'd2)
                        col_next = col_reg + 2'd1;
                    else
                    begin
                        col_next = 2'd0;
                        row_next = row_reg + 2'd1;
                        if (row_reg == 2'd2)
                            state_next = S_OUT;
                    end
                end
            S_OUT:
                if (!out_valid_reg || view.ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            yaw_reg       <= '0;
            pitch_reg     <= '0;
            trans_ph_reg  <= 1'b0;
            k_reg         <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            trans_ph_reg <= trans_ph_next;
            k_reg        <= k_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            if (accept)
            begin
                yaw_reg   <= yaw_next;
                pitch_reg <= pitch_next;
            end
            if (state_reg == S_OUT && (!out_valid_reg || view.ready))
                out_valid_reg <= 1'b1;
            else if (view.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg[0] <= cmd.position_x;
            pos_reg[1] <= cmd.position_y;
            pos_reg[2] <= cmd.position_z;
        end
        if (state_reg == S_PITCH)
        begin
            sy_reg <= yaw_reg[YAW_W-1] ? -rom_sin : rom_sin;
            cy_reg <= rom_cos;
        end
        if (state_reg == S_TRIG)
        begin
            sp_reg <= pitch_reg[PITCH_W-1] ? -rom_sin : rom_sin;
            cp_reg <= rom_cos;
            m_reg[0] <= sat_mtx(-64'(sy_reg));
            m_reg[1] <= '0;
            m_reg[2] <= sat_mtx(64'(cy_reg));
            m_reg[4] <= sat_mtx(64'(rom_cos));
            m_reg[7] <= sat_mtx(pitch_reg[PITCH_W-1] ? 64'(rom_sin) : -64'(rom_sin));
        end
        if (state_reg == S_WAIT && mac_done)
        begin
            if (!trans_ph_reg)
            begin
                unique case (k_reg)
                    2'd0: m_reg[3] <= sat_mtx(acc_sh);
                    2'd1: m_reg[5] <= sat_mtx(acc_sh);
                    2'd2: m_reg[6] <= sat_mtx(acc_sh);
                    default: m_reg[8] <= sat_mtx(acc_sh);
                endcase
            end
            else if (col_reg == 2'd2)
                t_reg[row_reg] <= sat_trans(acc_sh);
        end
        if (state_reg == S_OUT && (!out_valid_reg || view.ready))
        begin
            out_m_reg <= m_reg;
            out_t_reg <= t_reg;
        end
    end

    assign view.valid   = out_valid_reg;
    assign view.right_x = out_m_reg[0];
    assign view.right_y = out_m_reg[1];
    assign view.right_z = out_m_reg[2];
    assign view.up_x    = out_m_reg[3];
    assign view.up_y    = out_m_reg[4];
    assign view.up_z    = out_m_reg[5];
    assign view.back_x  = out_m_reg[6];
    assign view.back_y  = out_m_reg[7];
    assign view.back_z  = out_m_reg[8];
    assign view.trans_x = out_t_reg[0];
    assign view.trans_y = out_t_reg[1];
    assign view.trans_z = out_t_reg[2];

endmodule

/* rtl/ypvm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypvm_checker
// Port-level checks on the view matrix block, attached by bind.
// ----------------------------------------------------------------------------
module ypvm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] right_y,
    input logic [15:0] up_y,
    input logic [24:0] trans_x
);
    // a waiting item holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(trans_x))
        else $error("output item dropped or changed while stalled");

    // right vector has no vertical part
    a_right_y: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> right_y == 16'd0)
        else $error("right_y not zero");

    // pitch stays inside a quarter turn, so its cosine is never negative
    a_up_y: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !up_y[15])
        else $error("up_y negative");

    // no result appears the cycle after an item is taken
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too early");
endmodule

bind yaw_pitch_view_matrix_top ypvm_checker u_ypvm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (view.valid),
    .out_ready (view.ready),
    .right_y   (view.right_y),
    .up_y      (view.up_y),
    .trans_x   (view.trans_x)
);
